[sv/cflp_pkg.sv]
`timescale 1ns / 1ps

package cflp_pkg;

    localparam logic [1:0] CFG_BUFFER_LENGTH    = 2'd0;
    localparam logic [1:0] CFG_CROSSFADE_LENGTH = 2'd1;
    localparam logic [1:0] CFG_ENV_STEP         = 2'd2;

    localparam logic [16:0] BLEN_RESET = 17'd65536;
    localparam logic [15:0] XLEN_RESET = 16'd1024;
    localparam logic [26:0] STEP_RESET = 27'd65536;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_PLAIN = 2'd1;
    localparam logic [1:0] CMD_MIX   = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    localparam logic [25:0] PHASE_MAX   = 26'h3FFFFFF;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic        op;
        logic [15:0] address;
        logic [15:0] left_in;
        logic [15:0] right_in;
    } t_in;

    typedef struct packed {
        logic [15:0] left_out;
        logic [15:0] right_out;
        logic        in_crossfade;
    } t_out;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr_a;
        logic [15:0] addr_b;
        logic [25:0] phase;
        logic [15:0] left;
        logic [15:0] right;
    } t_cmd;

    // Rounded Q15 sine of a Q30 angle in the first quadrant, from a Taylor series.
    function automatic logic [15:0] f_quarter_sine(input logic [63:0] theta);
        logic [63:0]        t2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        q;
        t2   = (theta * theta) >> 30;
        term = theta;
        sum  = $signed(theta);
        term = ((term * t2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * t2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * t2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * t2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * t2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * t2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * t2) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        if (sum < 0) begin
            sum = 0;
        end
        q = ($unsigned(sum) + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[15:0];
    endfunction

endpackage

[sv/cflp_queue.sv]
`timescale 1ns / 1ps

module cflp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cflp_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output cflp_pkg::t_cmd  o_head
);

    cflp_pkg::t_cmd                     r_mem [cflp_pkg::QUEUE_DEPTH];
    logic [cflp_pkg::QUEUE_PTR_W-1:0]   r_wr_ptr;
    logic [cflp_pkg::QUEUE_PTR_W-1:0]   r_rd_ptr;
    logic [cflp_pkg::QUEUE_PTR_W:0]     r_count;

    assign o_full  = (r_count == (cflp_pkg::QUEUE_PTR_W + 1)'(cflp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/cflp_front.sv]
`timescale 1ns / 1ps

module cflp_front #(
    parameter int FRAME_DEPTH = 65536
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  cflp_pkg::t_in   i_in_data,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [26:0]     i_cfg_data,
    output logic            o_push,
    output cflp_pkg::t_cmd  o_cmd,
    input  logic            i_q_full
);

    localparam int BLEN_MAX = (FRAME_DEPTH < 65536) ? FRAME_DEPTH : 65536;
    localparam logic [1:0] CFG_SETTLE = 2'd3;

    logic [16:0] r_cfg_blen;
    logic [15:0] r_cfg_xlen;
    logic [26:0] r_cfg_step;
    logic [1:0]  r_cfg_wait;
    logic [16:0] r_blen;
    logic [15:0] r_xlen;
    logic [16:0] r_xpoint;
    logic [16:0] r_pos;
    logic [25:0] r_phase;
    logic [16:0] n_pos;
    logic [25:0] n_phase;

    logic [16:0] w_blen_clamp;
    logic [16:0] w_blen_m1;
    logic [15:0] w_xlen_clamp;
    logic [27:0] w_phase_sum;
    logic        w_accept;
    logic        w_push;
    cflp_pkg::t_cmd w_cmd;

    assign o_in_stall = i_q_full || (r_cfg_wait != 2'd0);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = w_push;
    assign o_cmd      = w_cmd;

    always_comb begin
        if (r_cfg_blen > 17'(BLEN_MAX)) begin
            w_blen_clamp = 17'(BLEN_MAX);
        end else if (r_cfg_blen < 17'd2) begin
            w_blen_clamp = 17'd2;
        end else begin
            w_blen_clamp = r_cfg_blen;
        end
    end

    assign w_blen_m1    = r_blen - 17'd1;
    assign w_xlen_clamp = ({1'b0, r_cfg_xlen} > w_blen_m1) ? w_blen_m1[15:0] : r_cfg_xlen;
    assign w_phase_sum  = 28'(r_phase) + 28'(r_cfg_step);

    always_ff @(posedge i_clk) begin
        r_blen   <= w_blen_clamp;
        r_xlen   <= w_xlen_clamp;
        r_xpoint <= r_blen - {1'b0, r_xlen};
    end

    always_comb begin
        n_pos        = r_pos;
        n_phase      = r_phase;
        w_cmd.kind   = cflp_pkg::CMD_LOAD;
        w_cmd.addr_a = i_in_data.address;
        w_cmd.addr_b = '0;
        w_cmd.phase  = r_phase;
        w_cmd.left   = i_in_data.left_in;
        w_cmd.right  = i_in_data.right_in;
        w_push       = 1'b0;
        if (i_in_data.op == cflp_pkg::OP_LOAD) begin
            w_push = w_accept && (32'(i_in_data.address) < 32'(FRAME_DEPTH));
        end else begin
            w_push = w_accept;
            if (r_pos >= r_blen) begin
                w_cmd.kind   = cflp_pkg::CMD_PLAIN;
                w_cmd.addr_a = r_xlen;
                n_pos        = {1'b0, r_xlen} + 17'd1;
                n_phase      = '0;
            end else if (r_pos >= r_xpoint) begin
                w_cmd.kind   = cflp_pkg::CMD_MIX;
                w_cmd.addr_a = r_pos[15:0];
                w_cmd.addr_b = 16'(r_pos - r_xpoint);
                n_pos        = r_pos + 17'd1;
                if (w_phase_sum > 28'(cflp_pkg::PHASE_MAX)) begin
                    n_phase = cflp_pkg::PHASE_MAX;
                end else begin
                    n_phase = w_phase_sum[25:0];
                end
            end else begin
                w_cmd.kind   = cflp_pkg::CMD_PLAIN;
                w_cmd.addr_a = r_pos[15:0];
                n_pos        = r_pos + 17'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_blen <= cflp_pkg::BLEN_RESET;
            r_cfg_xlen <= cflp_pkg::XLEN_RESET;
            r_cfg_step <= cflp_pkg::STEP_RESET;
            r_cfg_wait <= CFG_SETTLE;
            r_pos      <= '0;
            r_phase    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cflp_pkg::CFG_BUFFER_LENGTH: begin
                        r_cfg_blen <= i_cfg_data[16:0];
                    end
                    cflp_pkg::CFG_CROSSFADE_LENGTH: begin
                        r_cfg_xlen <= i_cfg_data[15:0];
                    end
                    cflp_pkg::CFG_ENV_STEP: begin
                        r_cfg_step <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
                r_cfg_wait <= CFG_SETTLE;
            end else if (r_cfg_wait != 2'd0) begin
                r_cfg_wait <= r_cfg_wait - 2'd1;
            end
            if (w_accept && (i_in_data.op == cflp_pkg::OP_TICK)) begin
                r_pos   <= n_pos;
                r_phase <= n_phase;
            end
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cfg_wait == 2'd0) |-> (r_xpoint == r_blen - {1'b0, r_xlen})
            && ({1'b0, r_xlen} < r_blen))
        else $error("Crossfade limits are not consistent with the loop length.");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("Command pushed into a full queue.");
`endif

endmodule

[sv/cflp_back.sv]
`timescale 1ns / 1ps

module cflp_back #(
    parameter int FRAME_DEPTH = 65536,
    parameter int ENV_SIZE    = 1024,
    parameter int CHANNELS    = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  cflp_pkg::t_cmd  i_q_head,
    output logic            o_q_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output cflp_pkg::t_out  o_out_data
);

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int DW = 16 * CHANNELS;
    localparam int EW = $clog2(ENV_SIZE);

    function automatic logic [15:0] f_round_sat(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
        logic signed [34:0] sum;
        logic signed [34:0] q;
        sum = 35'(a) + 35'(b) + 35'(16384);
        q   = sum >>> 15;
        if (q > 35'sd32767) begin
            return 16'h7FFF;
        end else if (q < -35'sd32768) begin
            return 16'h8000;
        end
        return q[15:0];
    endfunction

    logic [15:0] w_env_rom [ENV_SIZE];

    for (genvar g = 0; g < ENV_SIZE; g++) begin : g_rom
        localparam logic [63:0] THETA = (cflp_pkg::HALF_PI_Q30 * 64'(g)) / ENV_SIZE;
        assign w_env_rom[g] = cflp_pkg::f_quarter_sine(THETA);
    end

    logic [DW-1:0]      r_mem [FRAME_DEPTH];
    logic [DW-1:0]      r_rd_data;
    logic               w_adv;
    logic               w_pop;
    logic               w_mem_we;
    logic               w_mem_re;
    logic [AW-1:0]      w_mem_addr;
    logic [DW-1:0]      w_mem_wdata;
    logic               r_second;
    logic [15:0]        r_b_addr;

    logic [9:0]         w_y;
    logic [EW-1:0]      w_lo;
    logic [EW-1:0]      w_hi;
    logic [15:0]        r_rom_a;
    logic [15:0]        r_rom_b;
    logic               r_s1_valid;
    logic               r_s1_mix;
    logic [15:0]        r_s1_frac;

    logic signed [16:0] w_diff;
    logic signed [33:0] w_slope;
    logic signed [17:0] w_up_wide;
    logic               r_s2_valid;
    logic               r_s2_mix;
    logic signed [15:0] r_tail_l;
    logic signed [15:0] r_tail_r;
    logic [15:0]        r_up;

    logic signed [15:0] w_rd_left;
    logic signed [15:0] w_rd_right;
    logic [16:0]        w_down;
    logic signed [33:0] w_p_tl;
    logic signed [33:0] w_p_hl;
    logic signed [33:0] w_p_tr;
    logic signed [33:0] w_p_hr;
    logic               r_s3_valid;
    logic               r_s3_mix;
    logic signed [33:0] r_p_tl;
    logic signed [33:0] r_p_hl;
    logic signed [33:0] r_p_tr;
    logic signed [33:0] r_p_hr;

    logic               r_out_valid;
    cflp_pkg::t_out     r_out;

    // The whole pipeline, memory port included, holds while a result waits.
    assign w_adv       = !r_out_valid || !i_out_stall;
    assign w_pop       = w_adv && !r_second && !i_q_empty;
    assign o_q_pop     = w_pop;
    assign w_mem_we    = w_pop && (i_q_head.kind == cflp_pkg::CMD_LOAD);
    assign w_mem_re    = (w_adv && r_second)
                      || (w_pop && (i_q_head.kind != cflp_pkg::CMD_LOAD));
    assign w_mem_addr  = r_second ? AW'(r_b_addr) : AW'(i_q_head.addr_a);
    assign w_mem_wdata = DW'({i_q_head.right, i_q_head.left});

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_mem_addr];
        end
    end

    assign w_y  = i_q_head.phase[25:16];
    assign w_lo = (32'(w_y) < ENV_SIZE - 1) ? EW'(w_y) : EW'(ENV_SIZE - 1);
    assign w_hi = (32'(w_y) + 1 < ENV_SIZE - 1) ? EW'(32'(w_y) + 1) : EW'(ENV_SIZE - 1);

    assign w_diff    = $signed({1'b0, r_rom_b}) - $signed({1'b0, r_rom_a});
    assign w_slope   = 34'(w_diff) * 34'($signed({1'b0, r_s1_frac}));
    assign w_up_wide = $signed({2'b00, r_rom_a}) + 18'(w_slope >>> 16);

    assign w_rd_left  = r_rd_data[15:0];
    assign w_rd_right = (CHANNELS == 2) ? r_rd_data[DW-1 -: 16] : 16'sd0;
    assign w_down     = 17'd32768 - {1'b0, r_up};
    assign w_p_tl     = 34'(r_tail_l) * 34'($signed({1'b0, w_down}));
    assign w_p_hl     = 34'(w_rd_left) * 34'($signed({1'b0, r_up}));
    assign w_p_tr     = 34'(r_tail_r) * 34'($signed({1'b0, w_down}));
    assign w_p_hr     = 34'(w_rd_right) * 34'($signed({1'b0, r_up}));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_pop) begin
                r_b_addr <= i_q_head.addr_b;
            end
            r_s1_mix  <= (i_q_head.kind == cflp_pkg::CMD_MIX);
            r_s1_frac <= i_q_head.phase[15:0];
            r_rom_a   <= w_env_rom[w_lo];
            r_rom_b   <= w_env_rom[w_hi];
            r_s2_mix  <= r_s1_mix;
            r_tail_l  <= w_rd_left;
            r_tail_r  <= w_rd_right;
            r_up      <= r_s1_mix ? w_up_wide[15:0] : 16'd0;
            r_s3_mix  <= r_s2_mix;
            r_p_tl    <= w_p_tl;
            r_p_hl    <= w_p_hl;
            r_p_tr    <= w_p_tr;
            r_p_hr    <= w_p_hr;
            r_out.left_out     <= f_round_sat(r_p_tl, r_p_hl);
            r_out.right_out    <= f_round_sat(r_p_tr, r_p_hr);
            r_out.in_crossfade <= r_s3_mix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second    <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_second    <= w_pop && (i_q_head.kind == cflp_pkg::CMD_MIX);
            r_s1_valid  <= w_pop && (i_q_head.kind != cflp_pkg::CMD_LOAD);
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_second && w_adv) |=> !r_second)
        else $error("Head read lasted more than one advancing cycle.");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (r_s1_valid && r_s1_mix))
        else $error("Head read issued without a crossfade frame in flight.");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !r_s2_mix) |-> (r_up == 16'd0))
        else $error("Plain frame carries a nonzero head weight.");
`endif

endmodule

[sv/crossfade_loop_sample_player_top.sv]
`timescale 1ns / 1ps

// Looping stereo sample player with a quarter-sine crossfade at the loop end.
// Input channel (i_in_valid, o_in_stall, i_in_data): a load item with an address
// below FRAME_DEPTH writes one frame to the sample memory and gives no result; a
// tick item gives one result frame. Output channel (o_out_valid, i_out_stall,
// o_out_data) carries the played frames. Configuration is written through
// i_cfg_we, i_cfg_index and i_cfg_data. A load or a plain tick uses the single
// sample memory port once; a crossfade tick reads it twice, and the back end pops
// no new command during the second read. The front end takes one item per cycle
// while the four-entry queue is not full and no configuration write is settling.
// After reset the registers hold their default values, play position and phase
// are zero, and the input is stalled until the settle counter runs out; every
// configuration write restarts that counter. The sample memory is not cleared.
// While the receiver stalls a waiting result, the result is held and the back end
// pipeline freezes; the front end keeps accepting items until the queue is full.
module crossfade_loop_sample_player_top #(
    parameter int FRAME_DEPTH = 65536,
    parameter int ENV_SIZE    = 1024,
    parameter int CHANNELS    = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  cflp_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output cflp_pkg::t_out  o_out_data,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [26:0]     i_cfg_data
);

    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_empty;
    cflp_pkg::t_cmd w_push_cmd;
    cflp_pkg::t_cmd w_head_cmd;

    cflp_front #(
        .FRAME_DEPTH(FRAME_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd),
        .i_q_full   (w_full)
    );

    cflp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_cmd  (w_push_cmd),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_empty(w_empty),
        .o_head (w_head_cmd)
    );

    cflp_back #(
        .FRAME_DEPTH(FRAME_DEPTH),
        .ENV_SIZE   (ENV_SIZE),
        .CHANNELS   (CHANNELS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_empty),
        .i_q_head   (w_head_cmd),
        .o_q_pop    (w_pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

endmodule
